/* rtl/core/gbr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared types and constants of the 3x3 RGB Gaussian blur.
// ----------------------------------------------------------------------------
package gbr_pkg;

  // Default line store depth and configuration port geometry.
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int CFG_DW        = 16;
  localparam int CFG_IW        = 3;
  localparam int Q_DEPTH       = 4;

  // Register indexes.
  localparam logic [CFG_IW-1:0] REG_WIDTH    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_W_CORNER = 3'd2;
  localparam logic [CFG_IW-1:0] REG_W_EDGE   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_W_CENTER = 3'd4;

  // Register reset values.
  localparam logic [10:0] RST_WIDTH    = 11'd1024;
  localparam logic [15:0] RST_HEIGHT   = 16'd768;
  localparam logic [7:0]  RST_W_CORNER = 8'd16;
  localparam logic [7:0]  RST_W_EDGE   = 8'd32;
  localparam logic [7:0]  RST_W_CENTER = 8'd64;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } gbr_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } gbr_out_t;

  // Window rows: 0 = two rows up, 2 = current row; columns likewise.
  typedef logic [2:0][2:0][23:0] gbr_win_t;

  // One unit of work for the back end: a window plus its edge flags.
  typedef struct packed {
    gbr_win_t win;
    logic     top_row;
    logic     left_col;
    logic     last_col;
    logic     last_row;
  } gbr_job_t;

  typedef struct packed {
    logic [7:0] corner;
    logic [7:0] edge_w;
    logic [7:0] center;
  } gbr_weights_t;

endpackage : gbr_pkg
`default_nettype wire

/* rtl/core/gbr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_front
// Accepts pixels, tracks the raster position, keeps the two line stores and
// the 3x3 window, and hands finished windows to the job queue.
// ----------------------------------------------------------------------------
module gbr_front
  import gbr_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire gbr_in_t     in_data,
  input  wire logic [10:0] image_width,
  input  wire logic [15:0] image_height,
  output logic             job_valid,
  output gbr_job_t         job,
  input  wire logic        job_ready
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int WCW = (CW > 11) ? CW : 11;
  localparam logic [WCW-1:0] MAXW = WCW'(MAX_WIDTH);
  localparam logic [WCW-1:0] TWO  = WCW'(2);

  logic [23:0] older_mem [MAX_WIDTH];
  logic [23:0] prev_mem  [MAX_WIDTH];

  logic [XW-1:0]  col_r, col_nxt;
  logic [15:0]    row_r, row_nxt;
  logic [WCW-1:0] w_eff, w_ext, col_ext;
  logic [15:0]    h_eff, y_pos;
  logic [XW-1:0]  x_pos;
  logic           last_col, last_row, accept, commit;

  logic           s1_valid_r;
  logic [23:0]    pix_r, rd_old_r, rd_prev_r;
  logic [XW-1:0]  addr_r;
  logic           emit_r, top_r, left_r, lcol_r, lrow_r;
  gbr_win_t       win_r, win_nxt;

  // Effective frame size and clamped position.
  always_comb begin
    w_ext = WCW'(image_width);
    if (w_ext < TWO) begin
      w_eff = TWO;
    end else if (w_ext > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = w_ext;
    end
    h_eff   = (image_height < 16'd2) ? 16'd2 : image_height;
    col_ext = WCW'(col_r);
    x_pos   = (col_ext < w_eff) ? col_r : XW'(w_eff - WCW'(1));
    y_pos   = (row_r < h_eff) ? row_r : h_eff - 16'd1;
    last_col = (WCW'(x_pos) == w_eff - WCW'(1));
    last_row = (y_pos == h_eff - 16'd1);
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? 16'd0 : y_pos + 16'd1;
    end else begin
      col_nxt = x_pos + XW'(1);
      row_nxt = y_pos;
    end
  end

  assign commit   = s1_valid_r && job_ready;
  assign in_stall = s1_valid_r && !job_ready;
  assign accept   = in_valid && !in_stall;

  // Position counters and the read stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (commit) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_old_r  <= older_mem[x_pos];
      rd_prev_r <= prev_mem[x_pos];
      pix_r     <= in_data;
      addr_r    <= x_pos;
      emit_r    <= (x_pos != '0) && (y_pos != 16'd0);
      top_r     <= (y_pos == 16'd1);
      left_r    <= (x_pos == XW'(1));
      lcol_r    <= last_col;
      lrow_r    <= last_row;
    end
  end

  // Window shift: new column comes from the stores and the pixel.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = rd_old_r;
    win_nxt[1][2] = rd_prev_r;
    win_nxt[2][2] = pix_r;
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      win_r            <= win_nxt;
      older_mem[addr_r] <= rd_prev_r;
      prev_mem[addr_r]  <= pix_r;
    end
  end

  assign job_valid    = commit && emit_r;
  assign job.win      = win_nxt;
  assign job.top_row  = top_r;
  assign job.left_col = left_r;
  assign job.last_col = lcol_r;
  assign job.last_row = lrow_r;

endmodule : gbr_front
`default_nettype wire

/* rtl/core/gbr_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_queue
// Small FIFO of windows between the front end and the back end.
// ----------------------------------------------------------------------------
module gbr_queue
  import gbr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire gbr_job_t push_job,
  output logic          ready,
  input  wire logic     pop,
  output logic          head_valid,
  output gbr_job_t      head_job
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int NW = $clog2(Q_DEPTH + 1);

  gbr_job_t        slot_r [Q_DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [NW-1:0]   cnt_r;
  logic            do_pop;

  assign ready      = (cnt_r != NW'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_r];
  assign do_pop     = pop && head_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + PW'(1);
      end
      if (do_pop) begin
        rd_r <= rd_r + PW'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

endmodule : gbr_queue
`default_nettype wire

/* rtl/core/gbr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_back
// Turns each window into one to four blurred pixels: a sequencer picks the
// edge variant, a product stage weighs the taps, a sum stage drives the output.
// ----------------------------------------------------------------------------
module gbr_back
  import gbr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         head_valid,
  input  wire gbr_job_t     head_job,
  output logic              pop,
  input  wire gbr_weights_t weights,
  output logic              out_valid,
  input  wire logic         out_stall,
  output gbr_out_t          out_data
);

  logic [1:0]       idx_r;
  logic [1:0]       idx_next;
  logic             done, issue, p_take, out_load;
  logic [2:0][1:0]  rsel, csel;
  logic [2:0][2:0][2:0][7:0] term_nxt, term_r;
  logic             p_valid_r, p_end_r, out_valid_r;
  gbr_out_t         out_r;
  logic [23:0]      px;
  logic [7:0]       w, ch;
  logic [15:0]      prod;
  logic [2:0][7:0]  sums;

  // Next result of the current window, or done.
  always_comb begin
    idx_next = 2'd0;
    done     = 1'b1;
    unique case (idx_r)
      2'd0: begin
        if (head_job.last_col) begin
          idx_next = 2'd1;
          done     = 1'b0;
        end else if (head_job.last_row) begin
          idx_next = 2'd2;
          done     = 1'b0;
        end
      end
      2'd1: begin
        if (head_job.last_row) begin
          idx_next = 2'd2;
          done     = 1'b0;
        end
      end
      2'd2: begin
        if (head_job.last_col) begin
          idx_next = 2'd3;
          done     = 1'b0;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign out_load = p_valid_r && (!out_valid_r || !out_stall);
  assign p_take   = !p_valid_r || out_load;
  assign issue    = head_valid && p_take;
  assign pop      = issue && done;

  // Row and column selection with mirrored and clamped edges.
  always_comb begin
    if (idx_r[1]) begin
      rsel = {2'd2, 2'd2, 2'd1};
    end else begin
      rsel = {2'd2, 2'd1, head_job.top_row ? 2'd2 : 2'd0};
    end
    if (idx_r[0]) begin
      csel = {2'd2, 2'd2, 2'd1};
    end else begin
      csel = {2'd2, 2'd1, head_job.left_col ? 2'd2 : 2'd0};
    end
  end

  // Weighted taps, each truncated to eight bits.
  always_comb begin
    px   = '0;
    w    = '0;
    ch   = '0;
    prod = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        px = head_job.win[rsel[r]][csel[c]];
        if (r == 1 && c == 1) begin
          w = weights.center;
        end else if (r == 1 || c == 1) begin
          w = weights.edge_w;
        end else begin
          w = weights.corner;
        end
        for (int k = 0; k < 3; k++) begin
          ch   = px[8*(2-k) +: 8];
          prod = ch * w;
          term_nxt[k][r][c] = prod[15:8];
        end
      end
    end
  end

  // Sums wrap modulo 256.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sums[k] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          sums[k] = sums[k] + term_r[k][r][c];
        end
      end
    end
  end

  // Sequencer and pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        idx_r <= done ? 2'd0 : idx_next;
      end
      if (p_take) begin
        p_valid_r <= issue;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      term_r  <= term_nxt;
      p_end_r <= (idx_r == 2'd3);
    end
    if (out_load) begin
      out_r.red_out   <= sums[0];
      out_r.green_out <= sums[1];
      out_r.blue_out  <= sums[2];
      out_r.frame_end <= p_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule : gbr_back
`default_nettype wire

/* rtl/core/gaussian_blur_3x3_rgb_top.sv */
`default_nettype none
// Throughput: one pixel per cycle while in_stall is low; last-column and last-row
// pixels give the back end extra results, so the last row runs at about half rate.
// The rate is set by the single weighting unit: one result per cycle without out_stall.
// Reset (synchronous, rst_n low) clears counters, queue and valids and loads the
// default registers; line stores are not cleared.
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb_top
// Streaming 3x3 Gaussian blur of RGB pixels with line stores and job queue.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_rgb_top
  import gbr_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gbr_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output gbr_out_t               out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  logic [10:0]  width_r;
  logic [15:0]  height_r;
  gbr_weights_t wts_r;
  logic         job_valid, job_ready, head_valid, pop;
  gbr_job_t     job, head_job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= RST_WIDTH;
      height_r      <= RST_HEIGHT;
      wts_r.corner  <= RST_W_CORNER;
      wts_r.edge_w  <= RST_W_EDGE;
      wts_r.center  <= RST_W_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:    width_r      <= cfg_data[10:0];
        REG_HEIGHT:   height_r     <= cfg_data;
        REG_W_CORNER: wts_r.corner <= cfg_data[7:0];
        REG_W_EDGE:   wts_r.edge_w <= cfg_data[7:0];
        REG_W_CENTER: wts_r.center <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  gbr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .image_width(width_r), .image_height(height_r),
    .job_valid, .job, .job_ready
  );

  gbr_queue u_queue (
    .clk, .rst_n, .push(job_valid), .push_job(job), .ready(job_ready),
    .pop, .head_valid, .head_job
  );

  gbr_back u_back (
    .clk, .rst_n, .head_valid, .head_job, .pop, .weights(wts_r),
    .out_valid, .out_stall, .out_data
  );

endmodule : gaussian_blur_3x3_rgb_top
`default_nettype wire

/* tb/tb_gaussian_blur_3x3_rgb_top.sv */
// ----------------------------------------------------------------------------
// tb_gaussian_blur_3x3_rgb_top
// This testbench streams RGB frames through the 3x3 blur. Frames use several
// sizes and weight sets, including the extremes and out-of-range register
// values. A scoreboard predicts every blurred pixel and its frame-end flag.
// Each result transaction is checked in order against that prediction.
// Both channels idle at random, except during the final stretch.
// ----------------------------------------------------------------------------
module tb_gaussian_blur_3x3_rgb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gbr_pkg::*;

  localparam int MAX_W       = DEF_MAX_WIDTH;
  localparam int DRAIN       = 12;
  localparam int CYCLE_LIMIT = 400000;

  // Scoreboard: a streaming model of the blur and the queue of pixels it predicts.
  class blur_scoreboard;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [7:0]  w_corner, w_edge, w_center;
    logic [23:0] older_row[MAX_W];
    logic [23:0] prev_row[MAX_W];
    logic [23:0] win[3][3];
    int          col_cnt, row_cnt;
    gbr_out_t    pending_pixels[$];
    int          errors;

    function new();
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      w_corner   = RST_W_CORNER;
      w_edge     = RST_W_EDGE;
      w_center   = RST_W_CENTER;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        prev_row[i]  = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_WIDTH:    width_reg  = val[10:0];
        REG_HEIGHT:   height_reg = val[15:0];
        REG_W_CORNER: w_corner   = val[7:0];
        REG_W_EDGE:   w_edge     = val[7:0];
        REG_W_CENTER: w_center   = val[7:0];
        default: ;
      endcase
    endfunction

    // Each term is truncated on its own; the sum wraps at eight bits.
    function logic [7:0] blur_channel(int rows[3], int cols[3], int sh);
      logic [7:0]  sum;
      logic [7:0]  p, w;
      logic [15:0] prod;
      sum = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p = win[rows[r]][cols[c]][sh +: 8];
          if (r == 1 && c == 1) w = w_center;
          else if (r == 1 || c == 1) w = w_edge;
          else w = w_corner;
          prod = p * w;
          sum  = sum + prod[15:8];
        end
      end
      return sum;
    endfunction

    function void push_pixel(int rows[3], int cols[3], bit last);
      gbr_out_t o;
      o.red_out   = blur_channel(rows, cols, 16);
      o.green_out = blur_channel(rows, cols, 8);
      o.blue_out  = blur_channel(rows, cols, 0);
      o.frame_end = last;
      pending_pixels.push_back(o);
    endfunction

    // Shifts the window, updates the row stores and predicts the results due.
    function void note_pixel(gbr_in_t px);
      int w, h, x, y;
      int rows_mid[3], rows_bot[3], cols_mid[3], cols_right[3];
      w = width_reg;
      h = height_reg;
      if (w < 2) w = 2;
      if (w > MAX_W) w = MAX_W;
      if (h < 2) h = 2;
      x = (col_cnt < w) ? col_cnt : w - 1;
      y = (row_cnt < h) ? row_cnt : h - 1;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2]    = older_row[x];
      win[1][2]    = prev_row[x];
      win[2][2]    = px;
      older_row[x] = prev_row[x];
      prev_row[x]  = px;
      if (x >= 1 && y >= 1) begin
        rows_mid   = '{(y == 1) ? 2 : 0, 1, 2};
        rows_bot   = '{1, 2, 2};
        cols_mid   = '{(x == 1) ? 2 : 0, 1, 2};
        cols_right = '{1, 2, 2};
        push_pixel(rows_mid, cols_mid, 1'b0);
        if (x == w - 1) push_pixel(rows_mid, cols_right, 1'b0);
        if (y == h - 1) begin
          push_pixel(rows_bot, cols_mid, 1'b0);
          if (x == w - 1) push_pixel(rows_bot, cols_right, 1'b1);
        end
      end
      if (x + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col_cnt = x + 1;
        row_cnt = y;
      end
    endfunction

    function void check_result(gbr_out_t got);
      gbr_out_t exp_px;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, got);
        errors++;
        return;
      end
      exp_px = pending_pixels.pop_front();
      if (got.red_out !== exp_px.red_out) begin
        $display("%0t: red mismatch, expected %h actual %h",
                 $time, exp_px.red_out, got.red_out);
        errors++;
      end
      if (got.green_out !== exp_px.green_out) begin
        $display("%0t: green mismatch, expected %h actual %h",
                 $time, exp_px.green_out, got.green_out);
        errors++;
      end
      if (got.blue_out !== exp_px.blue_out) begin
        $display("%0t: blue mismatch, expected %h actual %h",
                 $time, exp_px.blue_out, got.blue_out);
        errors++;
      end
      if (got.frame_end !== exp_px.frame_end) begin
        $display("%0t: frame_end mismatch, expected %b actual %b",
                 $time, exp_px.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  gbr_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  gbr_out_t          out_data;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  blur_scoreboard sb = new();
  bit             quiet_phase;
  int             cycle_cnt;
  int             stall_left;

  gaussian_blur_3x3_rgb_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout watchdog.
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side back-pressure in random bursts.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
  end
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 15) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: record accepted pixels, check accepted results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pixel(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every predicted result has arrived and the back end has drained.
  task automatic wait_drained();
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic setup_frame(int w, int h, int wc, int we, int wm);
    wait_drained();
    write_reg(REG_WIDTH, CFG_DW'(w));
    write_reg(REG_HEIGHT, CFG_DW'(h));
    write_reg(REG_W_CORNER, CFG_DW'(wc));
    write_reg(REG_W_EDGE, CFG_DW'(we));
    write_reg(REG_W_CENTER, CFG_DW'(wm));
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one pixel transaction, sometimes after an idle burst.
  task automatic send_pixel(gbr_in_t px);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_pixels(int n);
    gbr_in_t px;
    for (int i = 0; i < n; i++) begin
      px.red_in   = rand_level();
      px.green_in = rand_level();
      px.blue_in  = rand_level();
      send_pixel(px);
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_level_pixels(int n, logic [7:0] lvl_a, logic [7:0] lvl_b);
    gbr_in_t px;
    for (int i = 0; i < n; i++) begin
      px = (i % 2 == 0) ? {lvl_a, lvl_b, lvl_a} : {lvl_b, lvl_a, lvl_b};
      send_pixel(px);
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    int w, h, sent;
    quiet_phase = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_WIDTH;
    cfg_data    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest frame, full weights so every sum wraps.
    setup_frame(2, 2, 255, 255, 255);
    send_level_pixels(4, 8'hFF, 8'hFF);
    // Zero weights over a checkerboard.
    setup_frame(3, 3, 0, 0, 0);
    send_level_pixels(9, 8'hFF, 8'h00);
    // Default kernel on a small random frame.
    setup_frame(4, 3, RST_W_CORNER, RST_W_EDGE, RST_W_CENTER);
    send_random_pixels(12);

    // Out-of-range sizes are raised to the minimum.
    setup_frame(0, 0, 255, 0, 128);
    send_random_pixels(4);
    setup_frame(1, 1, 1, 2, 3);
    send_random_pixels(4);
    // Tallest height, then shrink it part-way down the frame.
    setup_frame(2, 65535, 255, 255, 0);
    send_random_pixels(20);
    wait_drained();
    write_reg(REG_HEIGHT, CFG_DW'(12));
    send_random_pixels(4);

    // Random frames of small sizes.
    sent = 0;
    while (sent < 120) begin
      w = $urandom_range(2, 8);
      h = $urandom_range(2, 6);
      if (sent > 80) quiet_phase = 1'b1;
      setup_frame(w, h, rand_level(), rand_level(), rand_level());
      send_random_pixels(w * h);
      sent += w * h;
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
